[design/b58enc_pkg.sv]
// Shared types, constants and the character table of the base-58 encoder.
`timescale 1ns / 1ps
package b58enc_pkg;

   localparam int DIGIT_BITS = 6;
   localparam int CARRY_BITS = 8;
   localparam int LEN_BITS = 7;

   localparam logic [LEN_BITS-1:0] MAX_RESULTS = 7'd45;
   localparam logic [7:0] CHAR_ONE = 8'h31;

   // Reciprocal of 58 for the partial sum of one digit step.
   localparam int RECIP_58 = 1130;
   localparam int RECIP_SHIFT = 16;

   typedef enum logic [1:0] {
      STATUS_OK = 2'd0,
      STATUS_TOO_LONG = 2'd1,
      STATUS_NO_ROOM = 2'd2
   } status_type;

   typedef struct packed {
      logic [DIGIT_BITS-1:0] digit;
      logic [CARRY_BITS-1:0] carry;
   } digit_step_type;

   function automatic logic [7:0] b58_char(input logic [DIGIT_BITS-1:0] value);
      logic [DIGIT_BITS-1:0] v;
      logic [7:0] ch;
      v = (value >= 6'd58) ? value - 6'd58 : value;
      if (v < 6'd9) begin
         ch = 8'h31 + {2'b00, v};
      end else if (v < 6'd17) begin
         ch = 8'h41 + {2'b00, v - 6'd9};
      end else if (v < 6'd22) begin
         ch = 8'h4A + {2'b00, v - 6'd17};
      end else if (v < 6'd33) begin
         ch = 8'h50 + {2'b00, v - 6'd22};
      end else if (v < 6'd44) begin
         ch = 8'h61 + {2'b00, v - 6'd33};
      end else begin
         ch = 8'h6D + {2'b00, v - 6'd44};
      end
      return ch;
   endfunction

endpackage

[design/b58enc_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module b58enc_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 45
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/b58enc_div58.sv]
// One multiply-by-256-plus-carry step on a base-58 digit.
`timescale 1ns / 1ps
module b58enc_div58 (
   input  logic [b58enc_pkg::DIGIT_BITS-1:0] digit,
   input  logic [b58enc_pkg::CARRY_BITS-1:0] carry,
   output b58enc_pkg::digit_step_type        result
);
   import b58enc_pkg::*;

   // 256 * d = 4 * 58 * d + 24 * d, so only 24 * d + carry needs dividing.
   logic [10:0] partial;
   logic [20:0] product;
   logic [4:0]  quot_low;
   logic [10:0] remainder;

   assign partial = 11'(digit) * 11'd24 + 11'(carry);
   assign product = 21'(partial) * 21'(RECIP_58);
   assign quot_low = product[RECIP_SHIFT+4:RECIP_SHIFT];
   assign remainder = partial - 11'(quot_low) * 11'd58;

   assign result.digit = remainder[DIGIT_BITS-1:0];
   assign result.carry = {digit, 2'b00} + CARRY_BITS'(quot_low);

endmodule

[design/base58_encoder.sv]
// Base-58 encoder top level: byte intake, digit-store fold, and result emission.
// A leading zero byte or a byte past MAX_IN_BYTES is only counted; any other byte is folded
// into every stored digit, top index down, through the read-modify-write port of the store.
// After the final byte comes a too-long status, or, once the result is sized, a no-room status
// if it does not fit, else the leading '1's and the significant digits, held while rsp_ready is low.
// Reset is synchronous; the digit store reads as zero until the first pass of a string.
`timescale 1ns / 1ps
module base58_encoder #(
   parameter int MAX_IN_BYTES = 32,
   parameter int DIGIT_DEPTH = 45
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_is_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_char,
   output logic [1:0] rsp_status,
   output logic [6:0] rsp_needed_length,
   output logic       rsp_last_out,
   input  logic       csr_wr_en,
   input  logic [6:0] csr_wr_data
);
   import b58enc_pkg::*;

   localparam int IW = $clog2(DIGIT_DEPTH);
   localparam int BW = $clog2(MAX_IN_BYTES + 2);
   localparam int LW = $clog2(MAX_IN_BYTES + 1);
   localparam logic [IW-1:0] TOP_INDEX = IW'(DIGIT_DEPTH - 1);
   localparam logic [BW-1:0] MAX_COUNT = BW'(MAX_IN_BYTES);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FOLD,
      ST_FIN,
      ST_TOPCHK,
      ST_DECIDE,
      ST_ONES,
      ST_DRD,
      ST_DLD
   } state_type;

   state_type state_ff, state_in;
   logic [LEN_BITS-1:0]   cap_ff, cap_in;
   logic [LW-1:0]         lzc_ff, lzc_in;
   logic                  still_ff, still_in;
   logic [BW-1:0]         bc_ff, bc_in;
   logic [IW-1:0]         tt_ff, tt_in;
   logic                  fresh_ff, fresh_in;
   logic                  last_pend_ff, last_pend_in;
   logic [IW-1:0]         j_ff, j_in;
   logic [CARRY_BITS-1:0] carry_ff, carry_in;
   logic [IW-1:0]         k_ff, k_in;
   logic [LEN_BITS-1:0]   n_ff, n_in;
   logic [LEN_BITS-1:0]   need_ff, need_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_char_ff, rsp_char_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic [LEN_BITS-1:0]   rsp_need_ff, rsp_need_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  ram_we;
   logic [IW-1:0]         ram_raddr;
   logic [DIGIT_BITS-1:0] ram_rdata;
   logic [DIGIT_BITS-1:0] digit_rd;
   digit_step_type        step;

   logic                  out_free;
   logic                  do_clear;
   logic                  load;
   logic [7:0]            load_char;
   status_type            load_status;
   logic [LEN_BITS-1:0]   load_need;
   logic                  load_last;
   logic [BW-1:0]         bc_next;
   logic [LEN_BITS-1:0]   sig;
   logic                  final_beat;

   b58enc_ram #(
      .WIDTH(DIGIT_BITS),
      .DEPTH(DIGIT_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(j_ff),
      .wr_data(step.digit),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   b58enc_div58 u_step (
      .digit (digit_rd),
      .carry (carry_ff),
      .result(step)
   );

   assign digit_rd = fresh_ff ? '0 : ram_rdata;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign bc_next = (bc_ff <= MAX_COUNT) ? bc_ff + BW'(1) : bc_ff;
   assign sig = (digit_rd != '0) ? LEN_BITS'(DIGIT_DEPTH) - LEN_BITS'(tt_ff) : '0;
   assign final_beat = (n_ff + LEN_BITS'(1) == need_ff);

   always_comb begin
      state_in = state_ff;
      cap_in = csr_wr_en ? csr_wr_data : cap_ff;
      lzc_in = lzc_ff;
      still_in = still_ff;
      bc_in = bc_ff;
      tt_in = tt_ff;
      fresh_in = fresh_ff;
      last_pend_in = last_pend_ff;
      j_in = j_ff;
      carry_in = carry_ff;
      k_in = k_ff;
      n_in = n_ff;
      need_in = need_ff;
      ram_we = 1'b0;
      ram_raddr = k_ff;
      do_clear = 1'b0;
      load = 1'b0;
      load_char = 8'd0;
      load_status = STATUS_OK;
      load_need = '0;
      load_last = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            ram_raddr = TOP_INDEX;
            if (req_valid) begin
               bc_in = bc_next;
               last_pend_in = req_is_last;
               if (bc_next <= MAX_COUNT && !(still_ff && req_in_byte == 8'd0)) begin
                  still_in = 1'b0;
                  carry_in = req_in_byte;
                  j_in = TOP_INDEX;
                  state_in = ST_FOLD;
               end else begin
                  if (bc_next <= MAX_COUNT) begin
                     lzc_in = lzc_ff + LW'(1);
                  end
                  if (req_is_last) begin
                     state_in = ST_FIN;
                  end
               end
            end
         end
         ST_FOLD: begin
            ram_we = 1'b1;
            ram_raddr = (j_ff == '0) ? '0 : j_ff - IW'(1);
            carry_in = step.carry;
            if (step.digit != '0 && j_ff < tt_ff) begin
               tt_in = j_ff;
            end
            if (j_ff == '0) begin
               fresh_in = 1'b0;
               state_in = last_pend_ff ? ST_FIN : ST_IDLE;
            end else begin
               j_in = j_ff - IW'(1);
            end
         end
         ST_FIN: begin
            ram_raddr = tt_ff;
            if (bc_ff > MAX_COUNT) begin
               if (out_free) begin
                  load = 1'b1;
                  load_status = STATUS_TOO_LONG;
                  load_last = 1'b1;
                  do_clear = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_TOPCHK;
            end
         end
         ST_TOPCHK: begin
            need_in = LEN_BITS'(lzc_ff) + sig;
            k_in = tt_ff;
            n_in = '0;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (need_ff > cap_ff || need_ff > MAX_RESULTS) begin
               if (out_free) begin
                  load = 1'b1;
                  load_status = STATUS_NO_ROOM;
                  load_need = need_ff;
                  load_last = 1'b1;
                  do_clear = 1'b1;
                  state_in = ST_IDLE;
               end
            end else if (need_ff == '0) begin
               do_clear = 1'b1;
               state_in = ST_IDLE;
            end else if (lzc_ff != '0) begin
               state_in = ST_ONES;
            end else begin
               state_in = ST_DRD;
            end
         end
         ST_ONES: begin
            if (out_free) begin
               load = 1'b1;
               load_char = CHAR_ONE;
               load_last = final_beat;
               n_in = n_ff + LEN_BITS'(1);
               if (final_beat) begin
                  do_clear = 1'b1;
                  state_in = ST_IDLE;
               end else if (n_ff + LEN_BITS'(1) == LEN_BITS'(lzc_ff)) begin
                  state_in = ST_DRD;
               end
            end
         end
         ST_DRD: begin
            state_in = ST_DLD;
         end
         ST_DLD: begin
            if (out_free) begin
               load = 1'b1;
               load_char = b58_char(digit_rd);
               load_last = final_beat;
               n_in = n_ff + LEN_BITS'(1);
               if (final_beat) begin
                  do_clear = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  k_in = k_ff + IW'(1);
                  state_in = ST_DRD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (do_clear) begin
         lzc_in = '0;
         still_in = 1'b1;
         bc_in = '0;
         tt_in = TOP_INDEX;
         fresh_in = 1'b1;
      end

      rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && !rsp_ready);
      rsp_char_in = load ? load_char : rsp_char_ff;
      rsp_status_in = load ? load_status : rsp_status_ff;
      rsp_need_in = load ? load_need : rsp_need_ff;
      rsp_last_in = load ? load_last : rsp_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cap_ff <= 7'd64;
         lzc_ff <= '0;
         still_ff <= 1'b1;
         bc_ff <= '0;
         tt_ff <= TOP_INDEX;
         fresh_ff <= 1'b1;
         last_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cap_ff <= cap_in;
         lzc_ff <= lzc_in;
         still_ff <= still_in;
         bc_ff <= bc_in;
         tt_ff <= tt_in;
         fresh_ff <= fresh_in;
         last_pend_ff <= last_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      j_ff <= j_in;
      carry_ff <= carry_in;
      k_ff <= k_in;
      n_ff <= n_in;
      need_ff <= need_in;
      rsp_char_ff <= rsp_char_in;
      rsp_status_ff <= rsp_status_in;
      rsp_need_ff <= rsp_need_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_char = rsp_char_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_needed_length = rsp_need_ff;
   assign rsp_last_out = rsp_last_ff;

endmodule
